// ===== rtl/psrwg_pkg.sv =====
// Shared types, command codes and register constants of the synthesizer word generator.
`default_nettype none

package psrwg_pkg;

    localparam int FREQ_W = 23;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        OP_FREQ  = 2'd0,
        OP_LEVEL = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [FREQ_W-1:0] FREQ_MIN = 23'd34375;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 23'd4399999;

    localparam logic [WORD_W-1:0] REG4_RESET = 32'h00CC_803C;
    localparam logic [WORD_W-1:0] DIV_MASK   = 32'hFF8F_FFFF;
    localparam logic [WORD_W-1:0] LEVEL_MASK = 32'hFFFF_FFE7;

    // Reciprocals for exact division of the VCO figure by 10 and then by 1000.
    localparam logic [23:0] RECIP10    = 24'd6710887;
    localparam logic [19:0] RECIP1000  = 20'd536871;
    localparam logic [9:0]  FRAC_MOD   = 10'd1000;

    localparam logic [2:0] INIT_LAST = 3'd5;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [FREQ_W-1:0] freq_khz;
        logic [1:0]        level;
    } cmd_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] level;
        logic [2:0] code;
        logic       err;
        logic [8:0] ival;
        logic [9:0] fval;
    } calc_t;

    // Power-up sequence, register 5 first and register 0 last.
    function automatic logic [WORD_W-1:0] init_word(input logic [2:0] idx);
        logic [WORD_W-1:0] w;
        unique case (idx)
            3'd0:    w = 32'h0058_0005;
            3'd1:    w = REG4_RESET;
            3'd2:    w = 32'h0000_04B3;
            3'd3:    w = 32'h1B00_4E42;
            3'd4:    w = 32'h0800_E1A9;
            3'd5:    w = 32'h002C_0000;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/psrwg_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one synthesizer command per beat.
`default_nettype none

interface psrwg_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [psrwg_pkg::FREQ_W-1:0]  freq_khz;
    logic [1:0]                    level;

    modport source (output valid, output opcode, output freq_khz, output level, input ready);
    modport sink   (input valid, input opcode, input freq_khz, input level, output ready);
endinterface

`default_nettype wire

// ===== rtl/psrwg_word_if.sv =====
// Result channel: valid/ready handshake carrying one control word per beat.
`default_nettype none

interface psrwg_word_if;
    logic                          valid;
    logic                          ready;
    logic [psrwg_pkg::WORD_W-1:0]  word;
    logic                          last;
    logic                          error;

    modport source (output valid, output word, output last, output error, input ready);
    modport sink   (input valid, input word, input last, input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/psrwg_freq_calc.sv =====
// Three-stage pipeline deriving divider code, INT and FRAC from a command.
`default_nettype none

module psrwg_freq_calc (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire psrwg_pkg::cmd_t  in_cmd,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output psrwg_pkg::calc_t      out_calc
);
    import psrwg_pkg::*;

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic              s1_adv, s2_adv, s3_adv;

    op_t               s1_op_reg, s2_op_reg, s3_op_reg;
    logic [1:0]        s1_level_reg, s2_level_reg, s3_level_reg;
    logic [2:0]        s1_code_reg, s2_code_reg, s3_code_reg;
    logic              s1_err_reg, s2_err_reg, s3_err_reg;
    logic [FREQ_W-1:0] s1_vco_reg;
    logic [18:0]       s2_q10_reg, s3_q10_reg;
    logic [8:0]        s3_ival_reg;

    op_t               in_op;
    logic              in_err;
    logic [2:0]        in_code;
    logic [FREQ_W-1:0] in_vco;
    logic [46:0]       prod10;
    logic [38:0]       prod1000;
    logic [18:0]       int_scaled;
    logic [18:0]       frac_diff;

    assign s3_adv   = !s3_valid_reg || out_ready;
    assign s2_adv   = !s2_valid_reg || s3_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    assign in_op  = op_t'(in_cmd.opcode);
    assign in_err = (in_cmd.freq_khz < FREQ_MIN) || (in_cmd.freq_khz > FREQ_MAX);

    // Octave search: each doubling of the range lowers the divider code by one.
    always_comb
    begin
        priority if (in_cmd.freq_khz >= 23'd2200000)
            in_code = 3'd0;
        else if (in_cmd.freq_khz >= 23'd1100000)
            in_code = 3'd1;
        else if (in_cmd.freq_khz >= 23'd550000)
            in_code = 3'd2;
        else if (in_cmd.freq_khz >= 23'd275000)
            in_code = 3'd3;
        else if (in_cmd.freq_khz >= 23'd137500)
            in_code = 3'd4;
        else if (in_cmd.freq_khz >= 23'd68750)
            in_code = 3'd5;
        else
            in_code = 3'd6;
    end

    assign in_vco = in_cmd.freq_khz << in_code;

    assign prod10     = 47'(s1_vco_reg) * 47'(RECIP10);
    assign prod1000   = 39'(s2_q10_reg) * 39'(RECIP1000);
    assign int_scaled = 19'(s3_ival_reg) * 19'(FRAC_MOD);
    assign frac_diff  = s3_q10_reg - int_scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= in_valid && (in_op != OP_NONE);
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (s3_adv)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_op_reg    <= in_op;
            s1_level_reg <= in_cmd.level;
            s1_code_reg  <= in_code;
            s1_err_reg   <= in_err;
            s1_vco_reg   <= in_vco;
        end
        if (s2_adv)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_level_reg <= s1_level_reg;
            s2_code_reg  <= s1_code_reg;
            s2_err_reg   <= s1_err_reg;
            s2_q10_reg   <= prod10[44:26];
        end
        if (s3_adv)
        begin
            s3_op_reg    <= s2_op_reg;
            s3_level_reg <= s2_level_reg;
            s3_code_reg  <= s2_code_reg;
            s3_err_reg   <= s2_err_reg;
            s3_q10_reg   <= s2_q10_reg;
            s3_ival_reg  <= prod1000[37:29];
        end
    end

    assign out_valid      = s3_valid_reg;
    assign out_calc.op    = s3_op_reg;
    assign out_calc.level = s3_level_reg;
    assign out_calc.code  = s3_code_reg;
    assign out_calc.err   = s3_err_reg;
    assign out_calc.ival  = s3_ival_reg;
    assign out_calc.fval  = frac_diff[9:0];

endmodule

`default_nettype wire

// ===== rtl/pll_synth_register_word_generator_core.sv =====
// Top level: turns synthesizer commands into a stream of 32-bit control words.
//
// Commands arrive on cmd, one per beat; control words leave on res, one per beat,
// with last set on the final word of each command and error set on the single
// all-zero word that answers an out-of-range frequency request.
// A frequency command yields register 4 then register 0, a level command yields
// register 4, an init command yields the six power-up words R5 down to R0.
// Opcode 3 is accepted and dropped without any output.
// The first word of a command passes three pipeline stages, which compute the
// divider code, INT and FRAC, then a word sequencer that feeds the output
// register. The sequencer issues one word per cycle while the receiver takes
// words, so a command holds it for one, two or six words; commands queue
// behind it in the pipeline, and a new command is taken every cycle while
// space remains. When the receiver stalls, the output register holds its word
// and the pipeline fills up before cmd.ready falls.
// Reset empties the pipeline and sets the register 4 shadow to its power-up value.
`default_nettype none

module pll_synth_register_word_generator_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    psrwg_cmd_if.sink   cmd,
    psrwg_word_if.source res
);
    import psrwg_pkg::*;

    cmd_t              in_cmd;
    logic              calc_valid;
    logic              calc_ready;
    calc_t             calc;

    logic              em_valid_reg;
    logic [2:0]        em_idx_reg;
    op_t               em_op_reg;
    logic [1:0]        em_level_reg;
    logic [2:0]        em_code_reg;
    logic              em_err_reg;
    logic [WORD_W-1:0] em_r0_reg;

    logic [WORD_W-1:0] shadow_reg;
    logic [WORD_W-1:0] shadow_next;
    logic              shadow_wr;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_last_reg;
    logic              out_error_reg;

    logic              emit_go;
    logic [WORD_W-1:0] em_word;
    logic              em_last;
    logic              em_error;

    assign in_cmd.opcode   = cmd.opcode;
    assign in_cmd.freq_khz = cmd.freq_khz;
    assign in_cmd.level    = cmd.level;

    psrwg_freq_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_cmd    (in_cmd),
        .out_valid (calc_valid),
        .out_ready (calc_ready),
        .out_calc  (calc)
    );

    assign emit_go    = em_valid_reg && (!out_valid_reg || res.ready);
    assign calc_ready = !em_valid_reg || (emit_go && em_last);

    // Word selection for the current sequencer step; register 4 edits go
    // through the shadow so that each command sees the previous one's result.
    always_comb
    begin
        em_word     = '0;
        em_last     = 1'b1;
        em_error    = 1'b0;
        shadow_next = shadow_reg;
        shadow_wr   = 1'b0;
        unique case (em_op_reg)
            OP_FREQ:
            begin
                if (em_err_reg)
                    em_error = 1'b1;
                else if (em_idx_reg == 3'd0)
                begin
                    shadow_next = (shadow_reg & DIV_MASK) | (32'(em_code_reg) << 20);
                    shadow_wr   = 1'b1;
                    em_word     = shadow_next;
                    em_last     = 1'b0;
                end
                else
                    em_word = em_r0_reg;
            end
            OP_LEVEL:
            begin
                shadow_next = (shadow_reg & LEVEL_MASK) | (32'(em_level_reg) << 3);
                shadow_wr   = 1'b1;
                em_word     = shadow_next;
            end
            OP_INIT:
            begin
                shadow_next = REG4_RESET;
                shadow_wr   = 1'b1;
                em_word     = init_word(em_idx_reg);
                em_last     = (em_idx_reg == INIT_LAST);
            end
            OP_NONE:
            begin
                em_word = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg  <= 1'b0;
            em_idx_reg    <= 3'd0;
            em_op_reg     <= OP_NONE;
            out_valid_reg <= 1'b0;
            shadow_reg    <= REG4_RESET;
        end
        else
        begin
            if (calc_ready)
            begin
                em_valid_reg <= calc_valid;
                em_idx_reg   <= 3'd0;
                em_op_reg    <= calc.op;
            end
            else if (emit_go)
                em_idx_reg <= em_idx_reg + 3'd1;

            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;

            if (emit_go && shadow_wr)
                shadow_reg <= shadow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_ready)
        begin
            em_level_reg <= calc.level;
            em_code_reg  <= calc.code;
            em_err_reg   <= calc.err;
            em_r0_reg    <= (32'(calc.ival) << 15) | (32'(calc.fval) << 3);
        end
        if (emit_go)
        begin
            out_word_reg  <= em_word;
            out_last_reg  <= em_last;
            out_error_reg <= em_error;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.word  = out_word_reg;
    assign res.last  = out_last_reg;
    assign res.error = out_error_reg;

endmodule

`default_nettype wire
